@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked during reset too.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/locbc_pkg.sv @@
package locbc_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int SLOT_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int MAX_LEN_BYTES = 4;

   localparam logic [7:0] TAG_SEQUENCE = 8'h30;
   localparam logic [7:0] TAG_INTEGER = 8'h02;
   localparam logic [7:0] TAG_OCTETS = 8'h04;
   localparam logic [7:0] OP_BIND = 8'h60;
   localparam logic [7:0] OP_SEARCH = 8'h63;
   localparam logic [7:0] OP_SEARCH_REF = 8'h73;
   localparam logic [7:0] LEN_LONG = 8'h80;
   localparam logic [7:0] LEN_MASK = 8'h7f;

   localparam logic [15:0] PORT_PRIMARY_RESET = 16'd389;
   localparam logic [15:0] PORT_CATALOG_RESET = 16'd3268;

   localparam logic CSR_PRIMARY = 1'b0;
   localparam logic CSR_CATALOG = 1'b1;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_BIND = 2'd1;
   localparam logic [1:0] KIND_SEARCH = 2'd2;
   localparam logic [1:0] KIND_REF = 2'd3;

   // One job from the parser to the table engine.
   typedef struct packed {
      logic        clear;
      logic        valid_op;
      logic [1:0]  kind;
      logic        anon;
      logic [31:0] client;
      logic [31:0] now;
   } job_type;

   localparam int JOB_W = $bits(job_type);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

endpackage

@@ hw/rtl/locbc_parser.sv @@
module locbc_parser import locbc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic        func,
   input  logic [7:0]  payload_byte,
   input  logic        packet_last,
   input  logic [31:0] source_address,
   input  logic [31:0] dest_address,
   input  logic [15:0] source_port,
   input  logic [15:0] dest_port,
   input  logic [31:0] now_seconds,
   input  logic [15:0] port_primary,
   input  logic [15:0] port_catalog,
   output logic        job_valid,
   input  logic        job_ready,
   output job_type     job
);

   typedef enum logic [3:0] {
      S_OUTER_TAG, S_OUTER_LEN, S_MID_TAG, S_MID_LEN, S_OP_TAG, S_OP_LEN,
      S_VER_TAG, S_VER_LEN, S_NAME_TAG, S_NAME_LEN, S_DONE, S_FAIL
   } stage_type;

   stage_type   stage_ff, stage_in;
   logic [31:0] offset_ff, offset_in;
   logic [31:0] acc_ff, acc_in;
   logic [2:0]  left_ff, left_in;
   logic [7:0]  tag_ff, tag_in;
   logic [33:0] end_ff, end_in;
   logic [33:0] wait_ff, wait_in;
   logic        empty_ff, empty_in;

   // Length byte decode: len_fail on a malformed length, len_done when complete, else more bytes follow.
   logic        len_fail, len_done;
   logic [31:0] len_val;
   logic [2:0]  len_left_nx;
   logic [33:0] pos;
   logic [33:0] name_pos;
   logic        accept, is_server_d, is_server_s, good;

   assign in_ready = job_ready;
   assign accept = in_valid && in_ready;
   assign pos = {2'b00, offset_ff};

   always_comb begin
      len_fail = 1'b0;
      len_done = 1'b0;
      len_val = acc_ff;
      len_left_nx = left_ff;
      if (left_ff == 3'd0) begin
         if (payload_byte < LEN_LONG) begin
            len_val = {24'd0, payload_byte};
            len_done = 1'b1;
         end else if ((payload_byte & LEN_MASK) == 8'd0 ||
                      (payload_byte & LEN_MASK) > 8'(MAX_LEN_BYTES)) begin
            len_fail = 1'b1;
         end else begin
            len_left_nx = payload_byte[2:0];
            len_val = 32'd0;
         end
      end else begin
         len_val = {acc_ff[23:0], payload_byte};
         len_left_nx = left_ff - 3'd1;
         if (len_left_nx == 3'd0) begin
            if (len_val[31]) len_fail = 1'b1;
            else len_done = 1'b1;
         end
      end
   end

   assign name_pos = pos + 34'd1 + {2'b00, len_val};

   always_comb begin
      stage_in = stage_ff;
      acc_in = len_val;
      left_in = len_left_nx;
      tag_in = tag_ff;
      end_in = end_ff;
      wait_in = wait_ff;
      empty_in = empty_ff;
      case (stage_ff)
         S_OUTER_TAG: begin
            acc_in = acc_ff;
            left_in = 3'd0;
            stage_in = (payload_byte == TAG_SEQUENCE) ? S_OUTER_LEN : S_FAIL;
         end
         S_OUTER_LEN: begin
            if (len_fail) begin stage_in = S_FAIL; left_in = 3'd0; end
            else if (len_done) begin stage_in = S_MID_TAG; left_in = 3'd0; end
         end
         S_MID_TAG: begin
            acc_in = acc_ff;
            left_in = 3'd0;
            stage_in = (payload_byte == TAG_INTEGER) ? S_MID_LEN : S_FAIL;
         end
         S_MID_LEN: begin
            if (len_fail) begin stage_in = S_FAIL; left_in = 3'd0; end
            else if (len_done) begin
               wait_in = name_pos;
               stage_in = S_OP_TAG;
               left_in = 3'd0;
            end
         end
         S_OP_TAG: begin
            acc_in = acc_ff;
            left_in = left_ff;
            if (pos == wait_ff) begin
               left_in = 3'd0;
               if (payload_byte == OP_BIND || payload_byte == OP_SEARCH ||
                   payload_byte == OP_SEARCH_REF) begin
                  tag_in = payload_byte;
                  stage_in = S_OP_LEN;
               end else stage_in = S_FAIL;
            end
         end
         S_OP_LEN: begin
            if (len_fail) begin stage_in = S_FAIL; left_in = 3'd0; end
            else if (len_done) begin
               end_in = name_pos;
               left_in = 3'd0;
               stage_in = (tag_ff != OP_BIND || len_val < 32'd5) ? S_DONE : S_VER_TAG;
            end
         end
         S_VER_TAG: begin
            acc_in = acc_ff;
            left_in = 3'd0;
            stage_in = (payload_byte == TAG_INTEGER) ? S_VER_LEN : S_DONE;
         end
         S_VER_LEN: begin
            if (pos >= end_ff) begin
               acc_in = acc_ff; left_in = 3'd0; stage_in = S_DONE;
            end else if (len_fail) begin stage_in = S_DONE; left_in = 3'd0; end
            else if (len_done) begin
               left_in = 3'd0;
               if (name_pos + 34'd2 > end_ff) stage_in = S_DONE;
               else begin wait_in = name_pos; stage_in = S_NAME_TAG; end
            end
         end
         S_NAME_TAG: begin
            acc_in = acc_ff;
            left_in = left_ff;
            if (pos == wait_ff) begin
               left_in = 3'd0;
               stage_in = (payload_byte == TAG_OCTETS) ? S_NAME_LEN : S_DONE;
            end
         end
         S_NAME_LEN: begin
            if (pos >= end_ff) begin
               acc_in = acc_ff; left_in = 3'd0; stage_in = S_DONE;
            end else if (len_fail) begin stage_in = S_DONE; left_in = 3'd0; end
            else if (len_done) begin
               empty_in = (len_val == 32'd0);
               left_in = 3'd0;
               stage_in = S_DONE;
            end
         end
         default: begin
            acc_in = acc_ff;
            left_in = left_ff;
         end
      endcase
      offset_in = (offset_ff == 32'hffff_ffff) ? offset_ff : offset_ff + 32'd1;
   end

   assign is_server_d = dest_port == port_primary || dest_port == port_catalog;
   assign is_server_s = source_port == port_primary || source_port == port_catalog;
   assign good = stage_in >= S_VER_TAG && stage_in <= S_DONE &&
                 (is_server_d || is_server_s);

   always_comb begin
      job.clear = func;
      job.valid_op = !func && good;
      job.kind = (tag_in == OP_BIND) ? KIND_BIND :
                 (tag_in == OP_SEARCH) ? KIND_SEARCH : KIND_REF;
      job.anon = empty_in && (end_in <= {2'b00, offset_in});
      job.client = is_server_d ? source_address : dest_address;
      job.now = now_seconds;
      job_valid = in_valid && (func || packet_last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= S_OUTER_TAG;
         offset_ff <= 32'd0;
         acc_ff <= 32'd0;
         left_ff <= 3'd0;
         tag_ff <= 8'd0;
         end_ff <= 34'd0;
         wait_ff <= 34'd0;
         empty_ff <= 1'b0;
      end else if (accept && !func) begin
         if (packet_last) begin
            stage_ff <= S_OUTER_TAG;
            offset_ff <= 32'd0;
            acc_ff <= 32'd0;
            left_ff <= 3'd0;
            tag_ff <= 8'd0;
            end_ff <= 34'd0;
            wait_ff <= 34'd0;
            empty_ff <= 1'b0;
         end else begin
            stage_ff <= stage_in;
            offset_ff <= offset_in;
            acc_ff <= acc_in;
            left_ff <= left_in;
            tag_ff <= tag_in;
            end_ff <= end_in;
            wait_ff <= wait_in;
            empty_ff <= empty_in;
         end
      end
   end

endmodule

@@ hw/rtl/locbc_queue.sv @@
module locbc_queue import locbc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_data
);

   job_type              mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ff, rd_ff;
   logic [QPTR_W:0]      cnt_ff;
   logic                 push, pop;

   assign push_ready = cnt_ff != (QPTR_W + 1)'(QUEUE_DEPTH);
   assign pop_valid = cnt_ff != '0;
   assign pop_data = mem_ff[rd_ff];
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
      end
   end

endmodule

@@ hw/rtl/locbc_table.sv @@
module locbc_table import locbc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   output logic        job_ready,
   input  job_type     job,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_recorded,
   output logic [1:0]  rsp_op_kind,
   output logic [5:0]  rsp_slot,
   output logic [31:0] rsp_bind_total,
   output logic [31:0] rsp_anon_bind_total,
   output logic [31:0] rsp_search_total,
   output logic [31:0] rsp_search_ref_total,
   output logic        busy
);

   typedef enum logic [2:0] {
      T_IDLE, T_SCAN, T_READ, T_UPDATE, T_OUT
   } tstate_type;

   // Memories, one read and one write per cycle.
   logic [31:0] addr_mem [TABLE_ENTRIES];
   logic [31:0] first_mem [TABLE_ENTRIES];
   logic [31:0] last_mem [TABLE_ENTRIES];
   logic [127:0] cnt_mem [TABLE_ENTRIES];

   tstate_type        st_ff;
   job_type           job_ff;
   logic [CNT_W-1:0]  used_ff;
   logic [CNT_W-1:0]  idx_ff;
   logic [SLOT_W-1:0] slot_ff, best_ff;
   logic [31:0]       best_time_ff;
   logic              hit_ff, fresh_ff;
   logic [31:0]       rd_addr_ff, rd_last_ff, rd_first_ff;
   logic [127:0]      rd_cnt_ff;
   logic [SLOT_W-1:0] rd_idx;
   logic              rd_valid_ff;
   logic [SLOT_W-1:0] rd_at_ff;
   logic [127:0]      new_cnt;
   logic [31:0]       new_first;

   assign job_ready = st_ff == T_IDLE;
   assign busy = st_ff != T_IDLE;
   assign rd_idx = (st_ff == T_SCAN) ? idx_ff[SLOT_W-1:0] : slot_ff;

   always_ff @(posedge clock) begin
      rd_addr_ff <= addr_mem[rd_idx];
      rd_last_ff <= last_mem[rd_idx];
      rd_first_ff <= first_mem[rd_idx];
      rd_cnt_ff <= cnt_mem[rd_idx];
      rd_at_ff <= rd_idx;
   end

   always_comb begin
      new_cnt = fresh_ff ? 128'd0 : rd_cnt_ff;
      new_first = fresh_ff ? 32'd0 : rd_first_ff;
      if (new_first == 32'd0) new_first = job_ff.now;
      case (job_ff.kind)
         KIND_BIND: begin
            new_cnt[31:0] = new_cnt[31:0] + 32'd1;
            if (job_ff.anon) new_cnt[63:32] = new_cnt[63:32] + 32'd1;
         end
         KIND_SEARCH: new_cnt[95:64] = new_cnt[95:64] + 32'd1;
         default: new_cnt[127:96] = new_cnt[127:96] + 32'd1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (st_ff == T_UPDATE) begin
         addr_mem[slot_ff] <= job_ff.client;
         first_mem[slot_ff] <= new_first;
         last_mem[slot_ff] <= job_ff.now;
         cnt_mem[slot_ff] <= new_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= T_IDLE;
         used_ff <= '0;
         rsp_valid <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         case (st_ff)
            T_IDLE: begin
               if (job_valid) begin
                  job_ff <= job;
                  idx_ff <= '0;
                  hit_ff <= 1'b0;
                  rd_valid_ff <= 1'b0;
                  best_ff <= '0;
                  if (job.clear) used_ff <= '0;
                  else if (!job.valid_op) begin
                     rsp_valid <= 1'b1;
                     rsp_recorded <= 1'b0;
                     rsp_op_kind <= KIND_NONE;
                     rsp_slot <= '0;
                     rsp_bind_total <= '0;
                     rsp_anon_bind_total <= '0;
                     rsp_search_total <= '0;
                     rsp_search_ref_total <= '0;
                     st_ff <= T_OUT;
                  end else st_ff <= T_SCAN;
               end
            end
            T_SCAN: begin
               // Data read at rd_at_ff returns from a registered read of rd_idx.
               if (rd_valid_ff) begin
                  if (rd_at_ff < used_ff[SLOT_W-1:0] || used_ff ==
                      CNT_W'(TABLE_ENTRIES)) begin
                     if (rd_addr_ff == job_ff.client && !hit_ff &&
                         ({1'b0, rd_at_ff} < (SLOT_W + 1)'(used_ff))) begin
                        hit_ff <= 1'b1;
                        slot_ff <= rd_at_ff;
                     end
                     if (rd_at_ff == '0 || rd_last_ff < best_time_ff) begin
                        best_time_ff <= rd_last_ff;
                        best_ff <= rd_at_ff;
                     end
                  end
               end
               rd_valid_ff <= idx_ff < used_ff;
               if (idx_ff < used_ff) idx_ff <= idx_ff + 1'b1;
               if (!(idx_ff < used_ff) && !rd_valid_ff) begin
                  if (hit_ff) fresh_ff <= 1'b0;
                  else begin
                     fresh_ff <= 1'b1;
                     if (used_ff != CNT_W'(TABLE_ENTRIES)) begin
                        slot_ff <= used_ff[SLOT_W-1:0];
                        used_ff <= used_ff + 1'b1;
                     end else slot_ff <= best_ff;
                  end
                  st_ff <= T_READ;
               end
               if (!(idx_ff < used_ff) && rd_valid_ff) rd_valid_ff <= 1'b0;
            end
            T_READ: st_ff <= T_UPDATE;
            T_UPDATE: begin
               rsp_valid <= 1'b1;
               rsp_recorded <= 1'b1;
               rsp_op_kind <= job_ff.kind;
               rsp_slot <= 6'(slot_ff);
               rsp_bind_total <= new_cnt[31:0];
               rsp_anon_bind_total <= new_cnt[63:32];
               rsp_search_total <= new_cnt[95:64];
               rsp_search_ref_total <= new_cnt[127:96];
               st_ff <= T_OUT;
            end
            T_OUT: begin
               if (rsp_ready) begin
                  rsp_valid <= 1'b0;
                  st_ff <= T_IDLE;
               end
            end
            default: st_ff <= T_IDLE;
         endcase
      end
   end

endmodule

@@ hw/rtl/ldap_op_counter_by_client.sv @@
// A non-last byte is absorbed into the parser registers. A last byte's job waits in the job
// queue, then the table scans the used entries, updates one slot and registers the result.
// Throughput: one byte per cycle while the job queue has room; jobs drain one at a time.
// Reset (synchronous, active high) empties the table and the queue, restores the server
// ports to 389 and 3268 and rewinds the parser to the outer sequence tag.
`include "assert_macros.svh"
module ldap_op_counter_by_client import locbc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [7:0]  req_payload_byte,
   input  logic        req_packet_last,
   input  logic [31:0] req_source_address,
   input  logic [31:0] req_dest_address,
   input  logic [15:0] req_source_port,
   input  logic [15:0] req_dest_port,
   input  logic [31:0] req_now_seconds,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_recorded,
   output logic [1:0]  rsp_op_kind,
   output logic [5:0]  rsp_slot,
   output logic [31:0] rsp_bind_total,
   output logic [31:0] rsp_anon_bind_total,
   output logic [31:0] rsp_search_total,
   output logic [31:0] rsp_search_ref_total,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   logic [15:0] port_primary_ff, port_catalog_ff;
   logic        front_valid, front_ready, back_valid, back_ready, busy;
   job_type     front_job, back_job;

   // Configuration words are always accepted.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         port_primary_ff <= PORT_PRIMARY_RESET;
         port_catalog_ff <= PORT_CATALOG_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PRIMARY: port_primary_ff <= csr_data;
            CSR_CATALOG: port_catalog_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // The front end parses each byte word and hands packet-end and clear jobs on.
   locbc_parser u_parser (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready),
      .func(req_func), .payload_byte(req_payload_byte),
      .packet_last(req_packet_last),
      .source_address(req_source_address), .dest_address(req_dest_address),
      .source_port(req_source_port), .dest_port(req_dest_port),
      .now_seconds(req_now_seconds),
      .port_primary(port_primary_ff), .port_catalog(port_catalog_ff),
      .job_valid(front_valid), .job_ready(front_ready), .job(front_job)
   );

   locbc_queue u_queue (
      .clock(clock), .reset(reset),
      .push_valid(front_valid), .push_ready(front_ready), .push_data(front_job),
      .pop_valid(back_valid), .pop_ready(back_ready), .pop_data(back_job)
   );

   // The back end searches the client table and emits the result word for each packet-end job.
   locbc_table u_table (
      .clock(clock), .reset(reset),
      .job_valid(back_valid), .job_ready(back_ready), .job(back_job),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_recorded(rsp_recorded), .rsp_op_kind(rsp_op_kind), .rsp_slot(rsp_slot),
      .rsp_bind_total(rsp_bind_total), .rsp_anon_bind_total(rsp_anon_bind_total),
      .rsp_search_total(rsp_search_total),
      .rsp_search_ref_total(rsp_search_ref_total),
      .busy(busy)
   );

   // A result word is only shown while the back end is working on a job.
   `ASSERT_CLK(a_rsp_busy, clock, reset, rsp_valid |-> busy, "result without job")
   // An ignored packet reports all-zero counters.
   `ASSERT_CLK(a_zero_ignored, clock, reset,
      (rsp_valid && !rsp_recorded) |-> (rsp_bind_total == 32'd0 && rsp_op_kind == KIND_NONE),
      "ignored packet with data")
   // After reset the output is idle.
   `ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "output valid after reset")

endmodule

@@ test/ldap_op_counter_by_client_checker.sv @@
module ldap_op_counter_by_client_checker import locbc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_func,
   input  logic [7:0]  req_payload_byte,
   input  logic        req_packet_last,
   input  logic [31:0] req_source_address,
   input  logic [31:0] req_dest_address,
   input  logic [15:0] req_source_port,
   input  logic [15:0] req_dest_port,
   input  logic [31:0] req_now_seconds,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_recorded,
   input  logic [1:0]  rsp_op_kind,
   input  logic [5:0]  rsp_slot,
   input  logic [31:0] rsp_bind_total,
   input  logic [31:0] rsp_anon_bind_total,
   input  logic [31:0] rsp_search_total,
   input  logic [31:0] rsp_search_ref_total,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data,
   output int          mismatches,
   output int          outstanding,
   output int          words_checked,
   output int          words_recorded
);

   typedef enum logic [3:0] {
      PS_OUTER_TAG, PS_OUTER_LEN, PS_MID_TAG, PS_MID_LEN, PS_OP_TAG, PS_OP_LEN,
      PS_VER_TAG, PS_VER_LEN, PS_NAME_TAG, PS_NAME_LEN, PS_DONE, PS_FAIL
   } stage_t;

   typedef struct packed {
      logic        recorded;
      logic [1:0]  kind;
      logic [5:0]  slot;
      logic [31:0] binds;
      logic [31:0] anons;
      logic [31:0] searches;
      logic [31:0] refs;
   } tally_t;

   localparam int CTR_BIND = 0;
   localparam int CTR_ANON = 1;
   localparam int CTR_SEARCH = 2;
   localparam int CTR_REF = 3;

   logic [15:0] port_primary, port_catalog;
   int          used;
   logic [31:0] owner_addr [TABLE_ENTRIES];
   logic [31:0] first_stamp [TABLE_ENTRIES];
   logic [31:0] last_stamp [TABLE_ENTRIES];
   logic [31:0] tallies [TABLE_ENTRIES][4];

   stage_t      stage;
   logic [31:0] offset;
   logic [31:0] acc;
   int          len_left;
   logic [7:0]  op_tag;
   logic [63:0] body_end, wait_pos;
   logic        dn_empty;

   tally_t      pending_tallies[$];

   task automatic report(string field, logic [31:0] got, logic [31:0] want);
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, field, got, want);
      mismatches++;
   endtask

   function automatic void wipe_table();
      used = 0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         owner_addr[i] = '0;
         first_stamp[i] = '0;
         last_stamp[i] = '0;
         for (int k = 0; k < 4; k++) tallies[i][k] = '0;
      end
   endfunction

   function automatic void rewind();
      stage = PS_OUTER_TAG;
      len_left = 0;
      offset = '0;
      acc = '0;
      op_tag = '0;
      body_end = '0;
      wait_pos = '0;
      dn_empty = 1'b0;
   endfunction

   function automatic void go(stage_t s);
      stage = s;
      len_left = 0;
   endfunction

   // Returns -1 on a malformed length, 0 while more length bytes follow, 1 when done.
   function automatic int length_byte(logic [7:0] b);
      int nb;
      if (len_left == 0) begin
         if (b < LEN_LONG) begin
            acc = {24'd0, b};
            return 1;
         end
         nb = int'(b & LEN_MASK);
         if (nb == 0 || nb > MAX_LEN_BYTES) return -1;
         len_left = nb;
         acc = '0;
         return 0;
      end
      acc = {acc[23:0], b};
      len_left--;
      if (len_left != 0) return 0;
      return acc[31] ? -1 : 1;
   endfunction

   function automatic void parse(logic [7:0] b, logic [63:0] pos);
      int r;
      logic [63:0] name_pos;
      case (stage)
         PS_OUTER_TAG: go(b == TAG_SEQUENCE ? PS_OUTER_LEN : PS_FAIL);
         PS_OUTER_LEN: begin
            r = length_byte(b);
            if (r < 0) go(PS_FAIL); else if (r > 0) go(PS_MID_TAG);
         end
         PS_MID_TAG: go(b == TAG_INTEGER ? PS_MID_LEN : PS_FAIL);
         PS_MID_LEN: begin
            r = length_byte(b);
            if (r < 0) go(PS_FAIL);
            else if (r > 0) begin
               wait_pos = pos + 64'd1 + {32'd0, acc};
               go(PS_OP_TAG);
            end
         end
         PS_OP_TAG: begin
            // The messageID value is skipped until the protocolOp tag position.
            if (pos == wait_pos) begin
               if (b == OP_BIND || b == OP_SEARCH || b == OP_SEARCH_REF) begin
                  op_tag = b;
                  go(PS_OP_LEN);
               end else go(PS_FAIL);
            end
         end
         PS_OP_LEN: begin
            r = length_byte(b);
            if (r < 0) go(PS_FAIL);
            else if (r > 0) begin
               body_end = pos + 64'd1 + {32'd0, acc};
               if (op_tag != OP_BIND || acc < 5) go(PS_DONE); else go(PS_VER_TAG);
            end
         end
         PS_VER_TAG: go(b == TAG_INTEGER ? PS_VER_LEN : PS_DONE);
         PS_VER_LEN: begin
            if (pos >= body_end) go(PS_DONE);
            else begin
               r = length_byte(b);
               if (r < 0) go(PS_DONE);
               else if (r > 0) begin
                  name_pos = pos + 64'd1 + {32'd0, acc};
                  if (name_pos + 64'd2 > body_end) go(PS_DONE);
                  else begin
                     wait_pos = name_pos;
                     go(PS_NAME_TAG);
                  end
               end
            end
         end
         PS_NAME_TAG: begin
            if (pos == wait_pos) go(b == TAG_OCTETS ? PS_NAME_LEN : PS_DONE);
         end
         PS_NAME_LEN: begin
            if (pos >= body_end) go(PS_DONE);
            else begin
               r = length_byte(b);
               if (r < 0) go(PS_DONE);
               else if (r > 0) begin
                  dn_empty = (acc == 0);
                  go(PS_DONE);
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic int claim_slot(logic [31:0] addr);
      int s;
      for (int i = 0; i < used; i++)
         if (owner_addr[i] == addr) return i;
      if (used < TABLE_ENTRIES) begin
         s = used;
         used++;
      end else begin
         s = 0;
         for (int i = 1; i < TABLE_ENTRIES; i++)
            if (last_stamp[i] < last_stamp[s]) s = i;
      end
      owner_addr[s] = addr;
      first_stamp[s] = '0;
      last_stamp[s] = '0;
      for (int k = 0; k < 4; k++) tallies[s][k] = '0;
      return s;
   endfunction

   function automatic void account_word();
      tally_t      t;
      logic [31:0] client;
      logic        anon;
      int          s;
      if (req_func) begin
         wipe_table();
         return;
      end
      parse(req_payload_byte, {32'd0, offset});
      if (offset != '1) offset++;
      if (!req_packet_last) return;
      t = '0;
      if (stage < PS_VER_TAG || stage > PS_DONE) begin
         pending_tallies.push_back(t);
         rewind();
         return;
      end
      if (req_dest_port == port_primary || req_dest_port == port_catalog)
         client = req_source_address;
      else if (req_source_port == port_primary || req_source_port == port_catalog)
         client = req_dest_address;
      else begin
         pending_tallies.push_back(t);
         rewind();
         return;
      end
      // An anonymous bind only counts when the whole op body arrived.
      anon = dn_empty && (body_end <= {32'd0, offset});
      s = claim_slot(client);
      if (first_stamp[s] == 0) first_stamp[s] = req_now_seconds;
      last_stamp[s] = req_now_seconds;
      if (op_tag == OP_BIND) begin
         t.kind = KIND_BIND;
         tallies[s][CTR_BIND]++;
         if (anon) tallies[s][CTR_ANON]++;
      end else if (op_tag == OP_SEARCH) begin
         t.kind = KIND_SEARCH;
         tallies[s][CTR_SEARCH]++;
      end else begin
         t.kind = KIND_REF;
         tallies[s][CTR_REF]++;
      end
      t.recorded = 1'b1;
      t.slot = s[5:0];
      t.binds = tallies[s][CTR_BIND];
      t.anons = tallies[s][CTR_ANON];
      t.searches = tallies[s][CTR_SEARCH];
      t.refs = tallies[s][CTR_REF];
      pending_tallies.push_back(t);
      rewind();
   endfunction

   initial begin
      mismatches = 0;
      outstanding = 0;
      words_checked = 0;
      words_recorded = 0;
   end

   always @(posedge clock) begin
      tally_t want;
      if (reset) begin
         port_primary <= PORT_PRIMARY_RESET;
         port_catalog <= PORT_CATALOG_RESET;
         wipe_table();
         rewind();
         pending_tallies.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            words_checked++;
            if (rsp_recorded) words_recorded++;
            if (pending_tallies.size() == 0) begin
               report("unexpected result word", {31'd0, rsp_recorded}, 32'd0);
            end else begin
               want = pending_tallies.pop_front();
               if (rsp_recorded !== want.recorded)
                  report("recorded", {31'd0, rsp_recorded}, {31'd0, want.recorded});
               if (rsp_op_kind !== want.kind)
                  report("op_kind", {30'd0, rsp_op_kind}, {30'd0, want.kind});
               if (rsp_slot !== want.slot)
                  report("slot", {26'd0, rsp_slot}, {26'd0, want.slot});
               if (rsp_bind_total !== want.binds)
                  report("bind_total", rsp_bind_total, want.binds);
               if (rsp_anon_bind_total !== want.anons)
                  report("anon_bind_total", rsp_anon_bind_total, want.anons);
               if (rsp_search_total !== want.searches)
                  report("search_total", rsp_search_total, want.searches);
               if (rsp_search_ref_total !== want.refs)
                  report("search_ref_total", rsp_search_ref_total, want.refs);
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_PRIMARY) port_primary <= csr_data;
            else port_catalog <= csr_data;
         end
         if (req_valid && req_ready) account_word();
      end
      outstanding = pending_tallies.size();
   end

endmodule

@@ test/ldap_op_counter_by_client_tb.sv @@
module ldap_op_counter_by_client_tb import locbc_pkg::*;;

   // Generous bound: even with every word ending a packet that waits out a full
   // table scan and the longest receiver stall, a correct run ends well within
   // this limit.
   localparam int CYCLE_LIMIT = 2000000;
   localparam int WORD_TARGET = 1550;
   localparam int PHASES = 4;

   typedef logic [7:0] octets_t[$];

   localparam int FORM_INDEF = 5;
   localparam int FORM_TOO_LONG = 6;
   localparam int FORM_HUGE = 7;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_func = 1'b0;
   logic [7:0]  req_payload_byte = '0;
   logic        req_packet_last = 1'b0;
   logic [31:0] req_source_address = '0;
   logic [31:0] req_dest_address = '0;
   logic [15:0] req_source_port = '0;
   logic [15:0] req_dest_port = '0;
   logic [31:0] req_now_seconds = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_recorded;
   logic [1:0]  rsp_op_kind;
   logic [5:0]  rsp_slot;
   logic [31:0] rsp_bind_total;
   logic [31:0] rsp_anon_bind_total;
   logic [31:0] rsp_search_total;
   logic [31:0] rsp_search_ref_total;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_PRIMARY;
   logic [15:0] csr_data = '0;

   int mismatches, outstanding, words_checked, words_recorded;

   ldap_op_counter_by_client dut (.*);
   ldap_op_counter_by_client_checker checker_inst (.*);

   int          words_sent = 0;
   int          packets_sent = 0;
   int          cycles = 0;
   logic        receiver_hold = 1'b0;
   logic [15:0] cur_primary = PORT_PRIMARY_RESET;
   logic [15:0] cur_catalog = PORT_CATALOG_RESET;
   logic [31:0] clock_seconds = '0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog. If the run hangs, for example because a result word never
   // arrives, this ends it as a failure.
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Timeout after %0d cycles with %0d result words still due", cycles, outstanding);
      $display("Simulation FAILED");
      $finish;
   end

   // Receiver side: mostly ready, with short stalls and now and then a long one.
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (receiver_hold) begin
            rsp_ready <= 1'b0;
         end else if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else if ($urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // One long hold-off in the middle of the run. The sender keeps offering
   // bytes, so the job queue behind the parser fills and req_ready must drop.
   initial begin
      wait (words_sent >= 700);
      @(posedge clock);
      receiver_hold = 1'b1;
      repeat (400) @(posedge clock);
      receiver_hold = 1'b0;
   end

   // Drives one word and returns at the edge where it is taken. Valid is only
   // lowered when a gap follows, so it never drops and rises in one step.
   task automatic send_word(logic func, logic [7:0] b, logic last, logic [31:0] src,
                            logic [31:0] dst, logic [15:0] sp, logic [15:0] dp,
                            logic [31:0] now);
      int gap;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) gap = 0;
      else if (pick < 95) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 40);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_payload_byte <= b;
      req_packet_last <= last;
      req_source_address <= src;
      req_dest_address <= dst;
      req_source_port <= sp;
      req_dest_port <= dp;
      req_now_seconds <= now;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   // A clear word carries random junk in every other field; the block must
   // ignore all of it.
   task automatic send_clear();
      send_word(1'b1, 8'($urandom), 1'($urandom), $urandom, $urandom,
                16'($urandom), 16'($urandom), $urandom);
   endtask

   // Sends a packet byte by byte, sometimes with a table clear slipped in
   // between bytes, which must not disturb the parse in progress.
   task automatic send_packet(octets_t pkt, logic [31:0] src, logic [31:0] dst,
                              logic [15:0] sp, logic [15:0] dp, logic [31:0] now);
      for (int i = 0; i < pkt.size(); i++) begin
         if ($urandom_range(0, 99) == 0) send_clear();
         send_word(1'b0, pkt[i], i == pkt.size() - 1, src, dst, sp, dp, now);
      end
      packets_sent++;
   endtask

   // BER length in the given form: 0 short, 1..4 long with that many bytes,
   // or one of the malformed forms.
   function automatic octets_t ber_length(int value, int form);
      octets_t q;
      case (form)
         0: q.push_back(8'(value));
         FORM_INDEF: q.push_back(LEN_LONG);
         FORM_TOO_LONG: begin
            q.push_back(LEN_LONG | 8'(MAX_LEN_BYTES + 1));
            repeat (MAX_LEN_BYTES + 1) q.push_back(8'($urandom_range(0, 3)));
         end
         FORM_HUGE: begin
            // Four length bytes with the top bit set: 2^31 or more.
            q.push_back(LEN_LONG | 8'd4);
            q.push_back(8'($urandom_range(128, 255)));
            repeat (3) q.push_back(8'($urandom));
         end
         default: begin
            q.push_back(LEN_LONG | 8'(form));
            for (int i = form - 1; i >= 0; i--) q.push_back(8'(value >> (8 * i)));
         end
      endcase
      return q;
   endfunction

   function automatic int good_form();
      return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
   endfunction

   function automatic octets_t tlv(logic [7:0] tag, octets_t val, int form, int extra);
      octets_t q;
      q = {tag, ber_length(val.size() + extra, form), val};
      return q;
   endfunction

   function automatic octets_t random_octets(int n);
      octets_t q;
      repeat (n) q.push_back(8'($urandom));
      return q;
   endfunction

   // Builds one LDAP message. With broken set, one thing is spoiled: a tag,
   // a length encoding, the packet end, or the whole content.
   function automatic octets_t build_message(bit broken);
      octets_t body, id, pkt;
      int      op, flaw, bad_field, op_extra;
      int      forms [5];
      logic [7:0] op_code;
      op = $urandom_range(0, 2);
      flaw = broken ? $urandom_range(0, 5) : -1;
      bad_field = $urandom_range(0, 4);
      for (int i = 0; i < 5; i++) forms[i] = good_form();
      if (flaw == 3) forms[bad_field] = $urandom_range(FORM_INDEF, FORM_HUGE);
      op_code = (op == 0) ? OP_BIND : (op == 1) ? OP_SEARCH : OP_SEARCH_REF;
      if (flaw == 2) op_code = 8'($urandom);
      if (op == 0) begin
         // version INTEGER, name OCTET STRING (often empty), simple empty auth
         body = {tlv(TAG_INTEGER, random_octets($urandom_range(1, 2)), forms[3], 0),
                 tlv(TAG_OCTETS, random_octets(($urandom_range(0, 1) == 0) ? 0 :
                     $urandom_range(1, 5)), forms[4], 0),
                 8'h80, 8'h00};
      end else begin
         body = random_octets($urandom_range(0, 6));
      end
      // Sometimes the op length claims more than the packet holds.
      op_extra = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 3) : 0;
      id = random_octets($urandom_range(0, 3));
      pkt = {tlv(TAG_INTEGER, id, forms[1], 0), tlv(op_code, body, forms[2], op_extra)};
      if (flaw == 1) pkt[0] = 8'($urandom_range(5, 255));
      pkt = tlv(TAG_SEQUENCE, pkt, forms[0], 0);
      if (flaw == 0) pkt[0] = TAG_SEQUENCE ^ 8'($urandom_range(1, 255));
      if (flaw == 4) pkt = pkt[0:$urandom_range(0, pkt.size() - 2)];
      if (flaw == 5) pkt = random_octets($urandom_range(1, 12));
      return pkt;
   endfunction

   // Picks the packet's direction. Most packets hit one of the server ports on
   // one side; some hit none.
   task automatic send_random_packet(octets_t pkt, logic [31:0] client);
      logic [31:0] peer;
      logic [15:0] server, other;
      logic [31:0] now;
      int          pick;
      peer = $urandom;
      server = ($urandom_range(0, 1) == 0) ? cur_primary : cur_catalog;
      other = 16'($urandom);
      pick = $urandom_range(0, 9);
      if ($urandom_range(0, 9) == 0) now = $urandom;
      else begin
         clock_seconds += $urandom_range(0, 2);
         now = clock_seconds;
      end
      if (pick < 6) send_packet(pkt, client, peer, other, server, now);
      else if (pick < 9) send_packet(pkt, peer, client, server, other, now);
      else send_packet(pkt, client, peer, 16'($urandom), 16'($urandom), now);
   endtask

   function automatic logic [31:0] pick_client();
      if ($urandom_range(0, 9) < 6) return {8'd10, 16'd0, 8'($urandom_range(0, 79))};
      return $urandom;
   endfunction

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      // Trailing clears and partial packets may still sit in the job queue.
      repeat (100) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_PRIMARY) cur_primary = value;
      else cur_catalog = value;
   endtask

   initial begin
      octets_t     pkt;
      logic [15:0] p0, p1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part. An anonymous bind from an all-ones client at the
      // latest time, toward the primary server port.
      pkt = '{TAG_SEQUENCE, 8'h0c, TAG_INTEGER, 8'h01, 8'h01, OP_BIND, 8'h07,
              TAG_INTEGER, 8'h01, 8'h03, TAG_OCTETS, 8'h00, 8'h80, 8'h00};
      send_packet(pkt, '1, '0, 16'hffff, PORT_PRIMARY_RESET, '1);
      // A search reference with a long-form empty op length, from the server
      // side on the catalog port to a client at address zero.
      pkt = '{TAG_SEQUENCE, 8'h06, TAG_INTEGER, 8'h01, 8'h02, OP_SEARCH_REF,
              LEN_LONG | 8'h01, 8'h00};
      send_packet(pkt, '1, '0, PORT_CATALOG_RESET, 16'h0000, '0);
      send_clear();
      // Indefinite outer length must be ignored.
      pkt = '{TAG_SEQUENCE, LEN_LONG};
      send_packet(pkt, 32'h0a000001, '1, 16'h1234, PORT_PRIMARY_RESET, 32'd5);

      // Random part in several port settings, extremes included.
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph > 0) begin
            wait_idle();
            case (ph)
               1: begin p0 = 16'h0000; p1 = 16'hffff; end
               2: begin p0 = 16'hffff; p1 = 16'h0000; end
               default: begin p0 = 16'($urandom); p1 = 16'($urandom); end
            endcase
            write_csr(CSR_PRIMARY, p0);
            write_csr(CSR_CATALOG, p1);
         end
         while (words_sent < (ph + 1) * WORD_TARGET / PHASES) begin
            if ($urandom_range(0, 24) == 0) begin
               // A burst of short searches from fresh clients fills the table
               // and forces evictions, with many equal time stamps.
               repeat ($urandom_range(20, 40)) begin
                  pkt = '{TAG_SEQUENCE, 8'h05, TAG_INTEGER, 8'h01, 8'($urandom),
                          OP_SEARCH, 8'h00};
                  send_random_packet(pkt, $urandom);
               end
            end else if ($urandom_range(0, 39) == 0) begin
               send_clear();
            end else begin
               send_random_packet(build_message($urandom_range(0, 3) == 0), pick_client());
            end
         end
      end

      wait_idle();
      $display("Sent %0d words in %0d packets over %0d port settings.",
               words_sent, packets_sent, PHASES);
      $display("Checked %0d result words, %0d of them recorded operations.",
               words_checked, words_recorded);
      if (mismatches == 0 && outstanding == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
